/* rtl/ufpd_pkg.sv */
// shared types, character constants and hex helper for the form percent decoder
`default_nettype none

package ufpd_pkg;

	// character codes
	localparam logic [7:0] CHR_PLUS  = 8'h2b;
	localparam logic [7:0] CHR_PCT   = 8'h25;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	// escape progress codes
	localparam logic [1:0] HELD_NONE  = 2'd0;
	localparam logic [1:0] HELD_PCT   = 2'd1;
	localparam logic [1:0] HELD_DIGIT = 2'd2;

	// number of result slots per item
	localparam int unsigned MAX_RES = 3;

	// escape bytes carried between items
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] digit;
	} held_t;

	// results caused by one item, slot 0 goes out first
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] res_byte;
		logic [1:0]              res_cnt;
		logic                    str_last;
	} group_t;

	// hex digit check: {valid, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/ufpd_in_if.sv */
// encoded byte channel: valid, ready and one input byte with its end mark
`default_nettype none

interface ufpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);
endinterface

`default_nettype wire

/* rtl/ufpd_out_if.sv */
// decoded byte channel: valid, ready and one result byte with its end marks
`default_nettype none

interface ufpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       string_end;

	modport source (output valid, out_byte, run_end, string_end, input ready);
	modport sink   (input valid, out_byte, run_end, string_end, output ready);
endinterface

`default_nettype wire

/* rtl/url_form_percent_decoder.sv */
// top level of the form percent decoder: escape state, result group register, output sequencing
//
// Decodes a form-encoded byte string: '+' gives a space, '%' and two hex digits give one
// byte, and a broken escape comes out literally. One encoded byte is taken per clock as long
// as each byte causes at most one result and the output is not stalled; a byte that causes
// k results (k up to 3, on a broken escape) holds the result group register until all k
// have left, and the input waits meanwhile. Bytes that only extend an escape cause no result.
// Results leave one per cycle from the group register while the output is ready; ready on
// the input side is high while that register is empty or is handing over its last result.
`default_nettype none

module url_form_percent_decoder
	import ufpd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	ufpd_in_if.sink        enc_ch,
	ufpd_out_if.source     dec_ch
);

	held_t  held_q;
	held_t  held_nxt;
	group_t grp_new;
	group_t grp_s1;
	logic   in_fire;
	logic   out_fire;

	ufpd_decode u_dec (
		.in_byte  (enc_ch.in_byte),
		.in_last  (enc_ch.in_last),
		.held     (held_q),
		.grp      (grp_new),
		.held_nxt (held_nxt)
	);

	// handshakes
	assign out_fire     = dec_ch.valid && dec_ch.ready;
	assign enc_ch.ready = (grp_s1.res_cnt == 2'd0) ||
		((grp_s1.res_cnt == 2'd1) && dec_ch.ready);
	assign in_fire      = enc_ch.valid && enc_ch.ready;

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (in_fire) begin
			held_q <= held_nxt;
		end
	end

	// result group: load on a new item, shift out one result per accepted output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_s1 <= '0;
		end else if (in_fire) begin
			grp_s1 <= grp_new;
		end else if (out_fire) begin
			grp_s1.res_byte <= {8'h00, grp_s1.res_byte[2], grp_s1.res_byte[1]};
			grp_s1.res_cnt  <= grp_s1.res_cnt - 2'd1;
		end
	end

	// output side
	assign dec_ch.valid      = (grp_s1.res_cnt != 2'd0);
	assign dec_ch.out_byte   = grp_s1.res_byte[0];
	assign dec_ch.run_end    = (grp_s1.res_cnt == 2'd1);
	assign dec_ch.string_end = (grp_s1.res_cnt == 2'd1) && grp_s1.str_last;

endmodule

`default_nettype wire

/* rtl/ufpd_decode.sv */
// next-state and result logic for one encoded byte
`default_nettype none

module ufpd_decode
	import ufpd_pkg::*;
(
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  held_t      held,
	output group_t     grp,
	output held_t      held_nxt
);

	always_comb begin
		logic [4:0] hb;
		logic [4:0] hd;
		logic       pl_hold;
		logic [7:0] pl_byte;

		hb = hex_nib(in_byte);
		hd = hex_nib(held.digit);

		// byte taken as ordinary input
		pl_hold = (in_byte == CHR_PCT) && !in_last;
		pl_byte = (in_byte == CHR_PLUS) ? CHR_SPACE : in_byte;

		grp.res_byte = '0;
		grp.res_cnt  = 2'd0;
		grp.str_last = in_last;
		held_nxt.cnt   = pl_hold ? HELD_PCT : HELD_NONE;
		held_nxt.digit = held.digit;

		unique case (held.cnt)
			HELD_PCT: begin
				if (hb[4]) begin
					if (in_last) begin
						grp.res_byte[0] = CHR_PCT;
						grp.res_byte[1] = in_byte;
						grp.res_cnt     = 2'd2;
						held_nxt.cnt    = HELD_NONE;
					end else begin
						held_nxt.cnt   = HELD_DIGIT;
						held_nxt.digit = in_byte;
					end
				end else begin
					// broken escape after the percent sign
					grp.res_byte[0] = CHR_PCT;
					grp.res_byte[1] = pl_byte;
					grp.res_cnt     = pl_hold ? 2'd1 : 2'd2;
				end
			end
			HELD_DIGIT: begin
				if (hd[4] && hb[4]) begin
					grp.res_byte[0] = {hd[3:0], hb[3:0]};
					grp.res_cnt     = 2'd1;
					held_nxt.cnt    = HELD_NONE;
				end else begin
					// broken escape after one digit
					grp.res_byte[0] = CHR_PCT;
					grp.res_byte[1] = held.digit;
					grp.res_byte[2] = pl_byte;
					grp.res_cnt     = pl_hold ? 2'd2 : 2'd3;
				end
			end
			default: begin
				grp.res_byte[0] = pl_byte;
				grp.res_cnt     = pl_hold ? 2'd0 : 2'd1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/ufpd_checker.sv */
// port-level checks for the form percent decoder and their bind
`default_nettype none

module ufpd_checker (
	input  logic        clk,
	input  logic        arst_n,
	ufpd_in_if.sink     enc_ch,
	ufpd_out_if.source  dec_ch
);

	// string end only on the last result of an item
	a_str_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		dec_ch.valid && dec_ch.string_end |-> dec_ch.run_end)
		else $error("string_end without run_end");

	// a new item only enters once the previous item's results are all gone
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		enc_ch.valid && enc_ch.ready |->
			!dec_ch.valid || (dec_ch.run_end && dec_ch.ready))
		else $error("item accepted while results pending");

	// results of one item follow each other without a gap
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		dec_ch.valid && dec_ch.ready && !dec_ch.run_end |=> dec_ch.valid)
		else $error("gap inside a run of results");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_ch.valid && !dec_ch.ready |=>
			dec_ch.valid && $stable(dec_ch.out_byte) && $stable(dec_ch.run_end) &&
			$stable(dec_ch.string_end))
		else $error("stalled result changed");

endmodule

bind url_form_percent_decoder ufpd_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.enc_ch (enc_ch),
	.dec_ch (dec_ch)
);

`default_nettype wire

/* sim/tb_url_form_percent_decoder.sv */
// testbench for the form percent decoder: directed and random strings, scoreboard check
`default_nettype none

module tb_url_form_percent_decoder
	import ufpd_pkg::*;
();

	// one decoded byte with its end marks
	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       string_end;
	} dec_item_t;

	// one encoded byte with its end mark
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_item_t;

	// decode predictor and store of decoded bytes still to arrive
	class dec_scoreboard;
		dec_item_t  pending_q[$];
		dec_item_t  grp[$];
		logic [1:0] esc_cnt;
		logic [7:0] esc_digit;
		int         errors;

		function new();
			esc_cnt   = HELD_NONE;
			esc_digit = 8'h00;
			errors    = 0;
		endfunction

		// nibble value of an ascii hex digit, -1 when not a digit
		function int digit_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) begin
				return int'(c - 8'h30);
			end
			if (c >= 8'h61 && c <= 8'h66) begin
				return int'(c - 8'h61) + 10;
			end
			if (c >= 8'h41 && c <= 8'h46) begin
				return int'(c - 8'h41) + 10;
			end
			return -1;
		endfunction

		function void emit(logic [7:0] b);
			if (grp.size() < MAX_RES) begin
				grp.push_back('{b, 1'b0, 1'b0});
			end
		endfunction

		// byte seen with no escape under way
		function void plain_byte(logic [7:0] b, logic last);
			if (b == CHR_PCT && !last) begin
				esc_cnt = HELD_PCT;
			end else if (b == CHR_PLUS) begin
				emit(CHR_SPACE);
			end else begin
				emit(b);
			end
		endfunction

		// accepted input item: work out its decoded bytes
		function void note_input(logic [7:0] b, logic last);
			logic [1:0] prev;
			int         hi;
			int         lo;
			dec_item_t  tail;
			grp.delete();
			prev    = esc_cnt;
			esc_cnt = HELD_NONE;
			case (prev)
				HELD_PCT: begin
					if (digit_value(b) >= 0) begin
						if (last) begin
							emit(CHR_PCT);
							emit(b);
						end else begin
							esc_cnt   = HELD_DIGIT;
							esc_digit = b;
						end
					end else begin
						emit(CHR_PCT);
						plain_byte(b, last);
					end
				end
				HELD_DIGIT: begin
					hi = digit_value(esc_digit);
					lo = digit_value(b);
					if (hi >= 0 && lo >= 0) begin
						emit(8'(hi * 16 + lo));
					end else begin
						emit(CHR_PCT);
						emit(esc_digit);
						plain_byte(b, last);
					end
				end
				default: begin
					plain_byte(b, last);
				end
			endcase
			if (last) begin
				esc_cnt = HELD_NONE;
			end
			if (grp.size() > 0) begin
				tail            = grp.pop_back();
				tail.run_end    = 1'b1;
				tail.string_end = last;
				grp.push_back(tail);
			end
			foreach (grp[i]) begin
				pending_q.push_back(grp[i]);
			end
		endfunction

		// accepted result item against the oldest expected byte
		function void check_result(logic [7:0] d, logic re, logic se);
			dec_item_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected item: byte %h run_end %b string_end %b",
					$time, d, re, se);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (d !== e.data) begin
				$display("%0t: out_byte mismatch: expected %h actual %h", $time, e.data, d);
				errors++;
			end
			if (re !== e.run_end) begin
				$display("%0t: run_end mismatch: expected %b actual %b",
					$time, e.run_end, re);
				errors++;
			end
			if (se !== e.string_end) begin
				$display("%0t: string_end mismatch: expected %b actual %b",
					$time, e.string_end, se);
				errors++;
			end
		endfunction

		function void check_drained();
			if (pending_q.size() != 0) begin
				$display("%0t: %0d expected items never arrived, expected %h actual none",
					$time, pending_q.size(), pending_q[0].data);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ufpd_in_if  enc_ch();
	ufpd_out_if dec_ch();

	url_form_percent_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc_ch (enc_ch),
		.dec_ch (dec_ch)
	);

	dec_scoreboard sb;
	enc_item_t     stim_q[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

	function void add_byte(logic [7:0] b, logic last);
		stim_q.push_back('{b, last});
	endfunction

	function void mark_last();
		enc_item_t t;
		t      = stim_q.pop_back();
		t.last = 1'b1;
		stim_q.push_back(t);
	endfunction

	// hex digit in random case
	function logic [7:0] rand_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) begin
			return 8'(8'h30 + v);
		end
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function logic [7:0] rand_nonhex();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		while (sb.digit_value(c) >= 0) begin
			c = 8'($urandom_range(1, 255));
		end
		return c;
	endfunction

	// one random string: plain bytes, plus signs, well-formed and broken escapes, or noise
	function void add_string();
		int segs;
		int kind;
		segs = $urandom_range(1, 6);
		if ($urandom_range(0, 5) == 0) begin
			// noise string of arbitrary bytes
			for (int s = 0; s < segs; s++) begin
				add_byte(8'($urandom_range(1, 255)), 1'b0);
			end
		end else begin
			for (int s = 0; s < segs; s++) begin
				kind = $urandom_range(0, 9);
				case (kind)
					0, 1, 2: add_byte(8'($urandom_range(1, 255)), 1'b0);
					3: add_byte(CHR_PLUS, 1'b0);
					4, 5, 6: begin
						add_byte(CHR_PCT, 1'b0);
						add_byte(rand_hex(), 1'b0);
						add_byte(rand_hex(), 1'b0);
					end
					7: begin
						add_byte(CHR_PCT, 1'b0);
						add_byte(rand_nonhex(), 1'b0);
					end
					8: begin
						add_byte(CHR_PCT, 1'b0);
						add_byte(rand_hex(), 1'b0);
						add_byte(rand_nonhex(), 1'b0);
					end
					default: add_byte(CHR_PCT, 1'b0);
				endcase
			end
			// unfinished escape at the end of the string
			if ($urandom_range(0, 3) == 0) begin
				add_byte(CHR_PCT, 1'b0);
				if ($urandom_range(0, 1)) begin
					add_byte(rand_hex(), 1'b0);
				end
			end
		end
		mark_last();
	endfunction

	// drive one item and wait for its acceptance
	task automatic send_item(enc_item_t it);
		@(negedge clk);
		enc_ch.valid   <= 1'b1;
		enc_ch.in_byte <= it.data;
		enc_ch.in_last <= it.last;
		@(posedge clk);
		while (!enc_ch.ready) begin
			@(posedge clk);
		end
		sb.note_input(it.data, it.last);
	endtask

	task automatic idle_input(int n);
		@(negedge clk);
		enc_ch.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// sender: bursts of random length with random gaps
	task automatic drive_all();
		int idx;
		int burst;
		int gap;
		idx = 0;
		while (idx < stim_q.size()) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			for (int k = 0; k < burst && idx < stim_q.size(); k++) begin
				send_item(stim_q[idx]);
				idx++;
			end
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				idle_input(gap);
			end
		end
		idle_input(1);
	endtask

	// receiver: stall pattern switching between modes
	initial begin
		int mode;
		int len;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			len  = $urandom_range(20, 100);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: dec_ch.ready <= 1'b1;
					1: dec_ch.ready <= 1'($urandom_range(0, 1));
					default: dec_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && dec_ch.valid && dec_ch.ready) begin
			sb.check_result(dec_ch.out_byte, dec_ch.run_end, dec_ch.string_end);
		end
	end

	// main sequence
	initial begin
		arst_n         = 1'b0;
		enc_ch.valid   = 1'b0;
		enc_ch.in_byte = 8'h00;
		enc_ch.in_last = 1'b0;
		dec_ch.ready   = 1'b0;
		sb             = new();

		// directed: plain, plus, escapes in both cases, broken escapes, extremes
		add_byte(8'h41, 1'b0);
		add_byte(CHR_PLUS, 1'b0);
		add_byte(CHR_PCT, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h31, 1'b0);
		add_byte(CHR_PCT, 1'b0); add_byte(8'h66, 1'b0); add_byte(8'h46, 1'b0);
		add_byte(CHR_PCT, 1'b0); add_byte(CHR_PLUS, 1'b0);
		add_byte(CHR_PCT, 1'b0); add_byte(8'h37, 1'b0); add_byte(8'h7a, 1'b0);
		add_byte(CHR_PCT, 1'b0); add_byte(CHR_PCT, 1'b0);
		add_byte(8'h30, 1'b0); add_byte(8'h31, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'h01, 1'b1);
		// percent alone as the last byte
		add_byte(CHR_PCT, 1'b1);
		// percent and one digit at the end
		add_byte(CHR_PCT, 1'b0); add_byte(8'h61, 1'b1);
		add_byte(CHR_PLUS, 1'b1);
		// escape completed on the last byte
		add_byte(CHR_PCT, 1'b0); add_byte(8'h42, 1'b0); add_byte(8'h39, 1'b1);

		while (stim_q.size() < 450) begin
			add_string();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		drive_all();

		while (sb.pending_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
